FILE: sv/itoa_pkg.sv
// itoa_pkg: shared constants, beat and command types, state enums and the
// digit-to-ascii helper for the integer-to-ascii formatter
// no dependencies
package itoa_pkg;

    // width of the integer that is converted (8 to 64)
    localparam int VALUE_WIDTH = 64;
    // fixed width of the value field on the input beat
    localparam int IN_VALUE_W  = 64;

    // digit counts that cover the full range of VALUE_WIDTH bits
    localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int DEC_BITS   = DEC_DIGITS * 4;
    localparam int HEX_BITS   = HEX_DIGITS * 4;
    localparam int DIG_W      = (DEC_BITS > HEX_BITS) ? DEC_BITS : HEX_BITS;
    localparam int CNT_W      = $clog2(DIG_W + 1);
    localparam int BITCNT_W   = $clog2(VALUE_WIDTH);

    // format codes on the op field
    localparam logic [1:0] OP_UDEC = 2'd0;
    localparam logic [1:0] OP_SDEC = 2'd1;
    localparam logic [1:0] OP_HEX  = 2'd2;
    localparam logic [1:0] OP_BIN  = 2'd3;

    // ascii codes
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] CHAR_MINUS      = 8'h2d;
    localparam logic [7:0] CHAR_ALPHA_BASE = 8'h57;  // 'a' - 10
    localparam logic [3:0] DIGIT_TEN       = 4'd10;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_HEX,
        RADIX_BIN
    } radix_t;

    typedef struct packed {
        logic [1:0]            op;
        logic [IN_VALUE_W-1:0] value;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } out_beat_t;

    // load command from the sequencer to the character emitter
    typedef struct packed {
        logic   load;
        logic   minus;
        radix_t radix;
    } emit_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LAUNCH,
        S_CONV,
        S_WAIT
    } top_state_t;

    typedef enum logic [1:0] {
        E_IDLE,
        E_SKIP,
        E_SIGN,
        E_DIGIT
    } emit_state_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] d8;
        d8 = {4'b0000, d};
        if (d < DIGIT_TEN)
            digit_char = CHAR_ZERO + d8;
        else
            digit_char = CHAR_ALPHA_BASE + d8;
    endfunction

endpackage

FILE: sv/itoa_dabble.sv
// itoa_dabble: bit-serial binary to bcd converter (shift and add-3),
// one input bit per cycle, msb first
// depends on itoa_pkg
module itoa_dabble
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [itoa_pkg::VALUE_WIDTH-1:0]     mag,
    output logic                                 done,
    output logic [itoa_pkg::DEC_BITS-1:0]        bcd
);

    logic [itoa_pkg::VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [itoa_pkg::DEC_BITS-1:0]    bcd_reg, bcd_next;
    logic [itoa_pkg::DEC_BITS-1:0]    bcd_adj;
    logic [itoa_pkg::BITCNT_W-1:0]    cnt_reg, cnt_next;
    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic                             final_bit;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < itoa_pkg::DEC_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    assign final_bit = (cnt_reg == itoa_pkg::BITCNT_W'(itoa_pkg::VALUE_WIDTH - 1));

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = mag;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next = {bcd_adj[itoa_pkg::DEC_BITS-2:0], bin_reg[itoa_pkg::VALUE_WIDTH-1]};
            bin_next = bin_reg << 1;
            cnt_next = cnt_reg + itoa_pkg::BITCNT_W'(1);
            if (final_bit)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("bcd done without a conversion in flight");

endmodule

FILE: sv/itoa_emit.sv
// itoa_emit: character emitter; drops leading zero digits one per cycle,
// then shifts out sign and digits as ascii through an output register
// depends on itoa_pkg
module itoa_emit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  itoa_pkg::emit_cmd_t           cmd,
    input  logic [itoa_pkg::DIG_W-1:0]    digits,
    output logic                          busy,
    output logic                          out_valid,
    input  logic                          out_ready,
    output itoa_pkg::out_beat_t           out_data
);

    itoa_pkg::emit_state_t          state_reg, state_next;
    logic [itoa_pkg::DIG_W-1:0]     sh_reg, sh_next;
    logic [itoa_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                           bin_reg, bin_next;
    logic                           minus_reg, minus_next;
    logic                           out_valid_reg, out_valid_next;
    itoa_pkg::out_beat_t            out_data_reg, out_data_next;

    logic                           out_free;
    logic [3:0]                     lead;
    logic                           lead_zero;
    logic                           cnt_one;
    logic                           shift_en;
    logic                           out_load;
    logic                           load_sign;
    logic [itoa_pkg::CNT_W-1:0]     load_cnt;

    assign out_free  = !out_valid_reg || out_ready;
    assign lead      = bin_reg ? {3'b000, sh_reg[itoa_pkg::DIG_W-1]}
                               : sh_reg[itoa_pkg::DIG_W-1 -: 4];
    assign lead_zero = (lead == 4'd0);
    assign cnt_one   = (cnt_reg == itoa_pkg::CNT_W'(1));

    always_comb
    begin
        case (cmd.radix)
            itoa_pkg::RADIX_HEX: load_cnt = itoa_pkg::CNT_W'(itoa_pkg::HEX_DIGITS);
            itoa_pkg::RADIX_BIN: load_cnt = itoa_pkg::CNT_W'(itoa_pkg::VALUE_WIDTH);
            default:             load_cnt = itoa_pkg::CNT_W'(itoa_pkg::DEC_DIGITS);
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            itoa_pkg::E_IDLE:
                if (cmd.load)
                    state_next = itoa_pkg::E_SKIP;
            itoa_pkg::E_SKIP:
                if (cnt_one || !lead_zero)
                    state_next = minus_reg ? itoa_pkg::E_SIGN : itoa_pkg::E_DIGIT;
            itoa_pkg::E_SIGN:
                if (out_free)
                    state_next = itoa_pkg::E_DIGIT;
            itoa_pkg::E_DIGIT:
                if (out_free && cnt_one)
                    state_next = itoa_pkg::E_IDLE;
            default:
                state_next = itoa_pkg::E_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        shift_en  = 1'b0;
        out_load  = 1'b0;
        load_sign = 1'b0;
        case (state_reg)
            itoa_pkg::E_SKIP:
                shift_en = !cnt_one && lead_zero;
            itoa_pkg::E_SIGN:
            begin
                out_load  = out_free;
                load_sign = 1'b1;
            end
            itoa_pkg::E_DIGIT:
            begin
                out_load = out_free;
                shift_en = out_free;
            end
            default:
            begin
                shift_en  = 1'b0;
                out_load  = 1'b0;
                load_sign = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        sh_next        = sh_reg;
        cnt_next       = cnt_reg;
        bin_next       = bin_reg;
        minus_next     = minus_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (state_reg == itoa_pkg::E_IDLE && cmd.load)
        begin
            sh_next    = digits;
            cnt_next   = load_cnt;
            bin_next   = (cmd.radix == itoa_pkg::RADIX_BIN);
            minus_next = cmd.minus;
        end
        else if (shift_en)
        begin
            sh_next  = bin_reg ? (sh_reg << 1) : (sh_reg << 4);
            cnt_next = cnt_reg - itoa_pkg::CNT_W'(1);
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            if (load_sign)
            begin
                out_data_next.char_code = itoa_pkg::CHAR_MINUS;
                out_data_next.last      = 1'b0;
            end
            else
            begin
                out_data_next.char_code = itoa_pkg::digit_char(lead);
                out_data_next.last      = cnt_one;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= itoa_pkg::E_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg       <= sh_next;
        bin_reg      <= bin_next;
        minus_reg    <= minus_next;
        out_data_reg <= out_data_next;
    end

    assign busy      = (state_reg != itoa_pkg::E_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_digit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == itoa_pkg::E_DIGIT |-> cnt_reg != '0)
        else $error("digit phase with no digits left");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && !load_sign && cnt_one |=> state_reg == itoa_pkg::E_IDLE)
        else $error("emitter still busy after the final character");

endmodule

FILE: sv/integer_to_ascii_formatter.sv
// integer_to_ascii_formatter: decimal values pass through the bit-serial bcd
// loop, then up to DEC_DIGITS - 1 leading zero digits are dropped, then one
// character a cycle while out_ready holds; hex and binary skip the bcd loop.
// throughput: one value at a time; the next beat is taken once the final
// character sits in the output register.
// reset: rst_n async active low clears sequencer, converter and output valid
// depends on itoa_pkg, itoa_dabble, itoa_emit
module integer_to_ascii_formatter
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  itoa_pkg::in_beat_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output itoa_pkg::out_beat_t  out_data
);

    // sequencer state and captured beat
    itoa_pkg::top_state_t               state_reg, state_next;
    logic [itoa_pkg::VALUE_WIDTH-1:0]   mag_reg, mag_next;
    logic                               minus_reg, minus_next;
    itoa_pkg::radix_t                   radix_reg, radix_next;

    // input decode
    logic [itoa_pkg::VALUE_WIDTH-1:0]   in_v;
    logic                               in_neg;
    logic                               in_take;

    // converter and emitter hookup
    logic                               dab_start;
    logic                               dab_done;
    logic [itoa_pkg::DEC_BITS-1:0]      dab_bcd;
    itoa_pkg::emit_cmd_t                cmd;
    logic [itoa_pkg::DIG_W-1:0]         digit_word;
    logic                               emit_busy;

    // only the low VALUE_WIDTH bits take part; sign is the top one of those
    assign in_v    = in_data.value[itoa_pkg::VALUE_WIDTH-1:0];
    assign in_neg  = (in_data.op == itoa_pkg::OP_SDEC) && in_v[itoa_pkg::VALUE_WIDTH-1];
    assign in_take = in_valid && in_ready;

    always_comb
    begin
        mag_next   = mag_reg;
        minus_next = minus_reg;
        radix_next = radix_reg;
        if (in_take)
        begin
            // two's complement magnitude; the most negative value maps onto itself,
            // which is exactly its unsigned magnitude
            mag_next   = in_neg ? (~in_v + itoa_pkg::VALUE_WIDTH'(1)) : in_v;
            minus_next = in_neg;
            case (in_data.op)
                itoa_pkg::OP_HEX: radix_next = itoa_pkg::RADIX_HEX;
                itoa_pkg::OP_BIN: radix_next = itoa_pkg::RADIX_BIN;
                default:          radix_next = itoa_pkg::RADIX_DEC;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            itoa_pkg::S_IDLE:
                if (in_valid)
                    state_next = itoa_pkg::S_LAUNCH;
            itoa_pkg::S_LAUNCH:
                // decimal goes through the bcd loop, hex and binary load directly
                if (radix_reg == itoa_pkg::RADIX_DEC)
                    state_next = itoa_pkg::S_CONV;
                else
                    state_next = itoa_pkg::S_WAIT;
            itoa_pkg::S_CONV:
                if (dab_done)
                    state_next = itoa_pkg::S_WAIT;
            itoa_pkg::S_WAIT:
                // emitter drops busy once the final character is registered
                if (!emit_busy)
                    state_next = itoa_pkg::S_IDLE;
            default:
                state_next = itoa_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready   = 1'b0;
        dab_start  = 1'b0;
        cmd.load   = 1'b0;
        cmd.minus  = minus_reg;
        cmd.radix  = radix_reg;
        case (state_reg)
            itoa_pkg::S_IDLE:
                in_ready = 1'b1;
            itoa_pkg::S_LAUNCH:
                if (radix_reg == itoa_pkg::RADIX_DEC)
                    dab_start = 1'b1;
                else
                    cmd.load = 1'b1;
            itoa_pkg::S_CONV:
                cmd.load = dab_done;
            default:
            begin
                in_ready  = 1'b0;
                dab_start = 1'b0;
                cmd.load  = 1'b0;
            end
        endcase
    end

    // digits left-aligned in the emitter word, most significant digit on top
    always_comb
    begin
        case (radix_reg)
            itoa_pkg::RADIX_HEX:
                digit_word = itoa_pkg::DIG_W'(mag_reg)
                             << (itoa_pkg::DIG_W - itoa_pkg::HEX_BITS);
            itoa_pkg::RADIX_BIN:
                digit_word = itoa_pkg::DIG_W'(mag_reg)
                             << (itoa_pkg::DIG_W - itoa_pkg::VALUE_WIDTH);
            default:
                digit_word = itoa_pkg::DIG_W'(dab_bcd)
                             << (itoa_pkg::DIG_W - itoa_pkg::DEC_BITS);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= itoa_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        minus_reg <= minus_next;
        radix_reg <= radix_next;
    end

    // bit-serial bcd converter
    itoa_dabble u_dabble
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dab_start),
        .mag   (mag_reg),
        .done  (dab_done),
        .bcd   (dab_bcd)
    );

    // zero drop, sign and character output with its output register
    itoa_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .digits    (digit_word),
        .busy      (emit_busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_idle_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == itoa_pkg::S_IDLE |-> !emit_busy)
        else $error("new beat could be taken while characters are pending");

    a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        dab_done |-> state_reg == itoa_pkg::S_CONV)
        else $error("bcd result arrived outside the conversion phase");

endmodule
